/* sv/b64u_pkg.sv */
// shared types, constants and the character table of the base64url stream encoder
`default_nettype none

package b64u_pkg;

  // width of the output limit register
  localparam int LIMIT_WIDTH = 24;
  // output limit after reset
  localparam logic [LIMIT_WIDTH-1:0] OUTPUT_LIMIT_RESET = 24'd16777212;
  // default width of the per-message character counter
  localparam int COUNT_WIDTH_DEFAULT = 24;
  // most results one byte can cause
  localparam int MAX_RESULTS = 4;
  // '=' pad character
  localparam logic [7:0] PAD_CODE = 8'd61;
  // code sent with the overflow result
  localparam logic [7:0] OVERFLOW_CODE = 8'd0;

  // one result as it leaves the block
  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       ovf;
  } result_t;

  // all results of one byte, entry 0 first
  typedef struct packed {
    result_t [MAX_RESULTS-1:0] ent;
    logic [2:0]                num;
  } res_group_t;

  // url-safe alphabet: A-Z a-z 0-9 - _
  function automatic logic [7:0] char_of(input logic [5:0] v);
    logic [7:0] code;
    if (v < 6'd26) begin
      code = 8'(8'd65 + {2'b00, v});
    end else if (v < 6'd52) begin
      code = 8'(8'd71 + {2'b00, v});
    end else if (v < 6'd62) begin
      code = 8'({2'b00, v} - 8'd4);
    end else if (v == 6'd62) begin
      code = 8'd45;
    end else begin
      code = 8'd95;
    end
    return code;
  endfunction

endpackage

`default_nettype wire

/* sv/b64u_step.sv */
// combinational encode step: one byte plus message state gives a result group and next state
`default_nettype none

module b64u_step #(
  parameter int COUNT_WIDTH = b64u_pkg::COUNT_WIDTH_DEFAULT
) (
  input  wire logic [7:0]                         data_byte,
  input  wire logic                               final_byte,
  input  wire logic [b64u_pkg::LIMIT_WIDTH-1:0]   output_limit,
  input  wire logic [3:0]                         acc,
  input  wire logic [2:0]                         pend,
  input  wire logic [COUNT_WIDTH-1:0]             count,
  input  wire logic                               discarding,
  output b64u_pkg::res_group_t                    grp,
  output logic [3:0]                              acc_next,
  output logic [2:0]                              pend_next,
  output logic [COUNT_WIDTH-1:0]                  count_next,
  output logic                                    discarding_next
);
  import b64u_pkg::*;

  localparam int LW = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;
  // largest multiple of four the counter can hold
  localparam logic [LW-1:0] CAP = LW'(((64'd1 << COUNT_WIDTH) - 64'd1) & ~64'd3);

  logic [LW-1:0]          lim_w;
  logic [COUNT_WIDTH-1:0] lim;
  logic [11:0]            w;
  logic [5:0]             c0;
  logic [5:0]             c1;
  logic                   two;
  logic [3:0]             racc;
  logic [2:0]             rpend;
  logic                   ge0;
  logic                   ge1;
  logic                   ovf0;
  logic                   ovf1;
  logic                   ovf;
  logic [1:0]             nchar;
  logic [COUNT_WIDTH-1:0] cnt_after;
  logic [1:0]             pad_need;
  logic [1:0]             pad_room;
  logic [1:0]             npad;
  logic [2:0]             num;
  logic                   close_msg;

  // effective limit: low two bits cleared, capped to the counter range
  assign lim_w = LW'({output_limit[LIMIT_WIDTH-1:2], 2'b00});
  assign lim   = COUNT_WIDTH'((lim_w < CAP) ? lim_w : CAP);

  assign w = {acc, data_byte};

  // character groups for each number of bits held over
  always_comb begin
    case (pend)
      3'd2: begin
        c0    = w[9:4];
        c1    = {w[3:0], 2'b00};
        two   = final_byte;
        racc  = w[3:0];
        rpend = 3'd4;
      end
      3'd4: begin
        c0    = w[11:6];
        c1    = w[5:0];
        two   = 1'b1;
        racc  = w[3:0];
        rpend = 3'd0;
      end
      default: begin
        c0    = w[7:2];
        c1    = {w[1:0], 4'b0000};
        two   = final_byte;
        racc  = {2'b00, w[1:0]};
        rpend = 3'd2;
      end
    endcase
  end

  // limit check before each character
  assign ge0  = count >= lim;
  assign ge1  = ({1'b0, count} + 1'b1) >= {1'b0, lim};
  assign ovf0 = ge0;
  assign ovf1 = !ge0 && two && ge1;
  assign ovf  = ovf0 || ovf1;

  always_comb begin
    if (ovf0) begin
      nchar = 2'd0;
    end else if (ovf1) begin
      nchar = 2'd1;
    end else begin
      nchar = two ? 2'd2 : 2'd1;
    end
  end

  // pad with '=' up to a multiple of four, at most four results in all
  assign cnt_after = count + COUNT_WIDTH'(nchar);
  assign pad_need  = 2'(2'd0 - cnt_after[1:0]);
  assign pad_room  = 2'(3'd4 - {1'b0, nchar});
  assign npad      = (final_byte && !ovf) ?
                     ((pad_need < pad_room) ? pad_need : pad_room) : 2'd0;
  assign num       = discarding ? 3'd0 :
                     ovf ? 3'({1'b0, nchar} + 3'd1) :
                     3'({1'b0, nchar} + {1'b0, npad});

  // build the result group
  always_comb begin
    grp.num = num;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (i < int'(nchar)) begin
        grp.ent[i].code = char_of((i == 0) ? c0 : c1);
        grp.ent[i].ovf  = 1'b0;
      end else if (ovf) begin
        grp.ent[i].code = OVERFLOW_CODE;
        grp.ent[i].ovf  = 1'b1;
      end else begin
        grp.ent[i].code = PAD_CODE;
        grp.ent[i].ovf  = 1'b0;
      end
      grp.ent[i].last = (i == int'(num) - 1) && (final_byte || ovf);
    end
  end

  // next message state
  assign close_msg = discarding ? final_byte : (final_byte || ovf);
  always_comb begin
    acc_next        = acc;
    pend_next       = pend;
    count_next      = count;
    discarding_next = discarding;
    if (close_msg) begin
      acc_next        = '0;
      pend_next       = '0;
      count_next      = '0;
      discarding_next = !discarding && ovf && !final_byte;
    end else if (!discarding) begin
      acc_next   = racc;
      pend_next  = rpend;
      count_next = cnt_after;
    end
  end

endmodule

`default_nettype wire

/* sv/b64u_out_reg.sv */
// result register: holds one byte's result group and hands it out one transfer per cycle while m_tready is high
`default_nettype none

module b64u_out_reg (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire b64u_pkg::res_group_t grp,
  input  wire logic                 load,
  output logic                      can_load,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [7:0]                m_tdata,  // char_code[7:0]
  output logic                      m_tlast,  // last_char
  output logic [0:0]                m_tuser   // overflow
);
  import b64u_pkg::*;

  result_t [MAX_RESULTS-1:0] ent;
  logic [2:0]                remain;
  logic [1:0]                idx;
  logic                      take;

  assign m_tvalid = remain != 3'd0;
  assign take     = m_tvalid && m_tready;
  assign can_load = (remain == 3'd0) || (remain == 3'd1 && take);

  assign m_tdata    = ent[idx].code;
  assign m_tlast    = ent[idx].last;
  assign m_tuser[0] = ent[idx].ovf;

  // group count and read pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= '0;
      idx    <= '0;
    end else if (load) begin
      remain <= grp.num;
      idx    <= '0;
    end else if (take) begin
      remain <= remain - 3'd1;
      idx    <= idx + 2'd1;
    end
  end

  // group payload
  always_ff @(posedge clk) begin
    if (load) begin
      ent <= grp.ent;
    end
  end

endmodule

`default_nettype wire

/* sv/base64url_stream_encoder_top.sv */
// top level of the base64url stream encoder: limit register, input register, message state and result register
`default_nettype none

// Encodes a byte stream into URL-safe base64 (A-Z a-z 0-9 - _), tlast marking
// the final byte of a message; the characters of a message are followed by '='
// pads up to a multiple of four, and the last result of the message (the last
// pad where there is one) carries tlast. If a character would pass
// output_limit (low two bits ignored) one result with code 0 and tuser set closes
// the message and the rest of its input is dropped. A byte is taken into the
// input register and encoded from there; its result group is loaded into the
// result register once that register can take it, and its results then leave
// one per cycle while m_tready is high (one or two, up to four at message end,
// none for a dropped byte), while the next byte waits in the input register.
module base64url_stream_encoder_top #(
  parameter int COUNT_WIDTH = b64u_pkg::COUNT_WIDTH_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_wr_en,
  input  wire logic [b64u_pkg::LIMIT_WIDTH-1:0]   cfg_wr_data,  // output_limit
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [7:0]                         s_tdata,      // data_byte[7:0]
  input  wire logic                               s_tlast,      // final_byte
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic [7:0]                              m_tdata,      // char_code[7:0]
  output logic                                    m_tlast,      // last_char
  output logic [0:0]                              m_tuser       // overflow
);
  import b64u_pkg::*;

  logic [LIMIT_WIDTH-1:0] output_limit;
  logic                   in_valid;
  logic [7:0]             in_byte;
  logic                   in_fin;
  logic [3:0]             acc;
  logic [3:0]             acc_next;
  logic [2:0]             pend;
  logic [2:0]             pend_next;
  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_next;
  logic                   discarding;
  logic                   discarding_next;
  res_group_t             grp;
  logic                   can_load;
  logic                   advance;

  assign advance  = in_valid && can_load;
  assign s_tready = !in_valid || can_load;

  // limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      output_limit <= OUTPUT_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      output_limit <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_fin  <= s_tlast;
    end
  end

  // message state
  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      pend       <= '0;
      count      <= '0;
      discarding <= 1'b0;
    end else if (advance) begin
      acc        <= acc_next;
      pend       <= pend_next;
      count      <= count_next;
      discarding <= discarding_next;
    end
  end

  b64u_step #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .data_byte       (in_byte),
    .final_byte      (in_fin),
    .output_limit    (output_limit),
    .acc             (acc),
    .pend            (pend),
    .count           (count),
    .discarding      (discarding),
    .grp             (grp),
    .acc_next        (acc_next),
    .pend_next       (pend_next),
    .count_next      (count_next),
    .discarding_next (discarding_next)
  );

  b64u_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .grp      (grp),
    .load     (advance),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire
